FILE: hw/rtl/rlp_pkg.sv
// Package with the field widths and derived sizes of the run-length pair bit packer.
package rlp_pkg;

	localparam int VALUE_BITS = 8;
	localparam int RUN_BITS = 8;
	localparam int WORD_BITS = 32;

	localparam int IN_VALUE_W = 8;
	localparam int IN_RUN_W = 8;
	localparam int OUT_WORD_W = 32;

	localparam int PAIR_BITS = VALUE_BITS + RUN_BITS;
	localparam int ACC_BITS = WORD_BITS + PAIR_BITS;
	localparam int CNT_W = $clog2(ACC_BITS + 1);

	typedef logic [IN_VALUE_W-1:0] pixel_value_t;
	typedef logic [IN_RUN_W-1:0] run_length_t;
	typedef logic [OUT_WORD_W-1:0] packed_word_t;
	typedef logic [ACC_BITS-1:0] acc_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

FILE: hw/rtl/rlp_in_if.sv
// Channel interface that carries one run-length pair per word.
interface rlp_in_if;
	logic valid;
	logic ready;
	rlp_pkg::pixel_value_t pixel_value;
	rlp_pkg::run_length_t run_length;

	modport source (output valid, output pixel_value, output run_length, input ready);
	modport sink (input valid, input pixel_value, input run_length, output ready);
endinterface

FILE: hw/rtl/rlp_out_if.sv
// Channel interface that carries one packed output word per word.
interface rlp_out_if;
	logic valid;
	logic ready;
	rlp_pkg::packed_word_t packed_word;
	logic last_of_item;

	modport source (output valid, output packed_word, output last_of_item, input ready);
	modport sink (input valid, input packed_word, input last_of_item, output ready);
endinterface

FILE: hw/rtl/run_length_pair_bit_packer.sv
// Top level of the run-length pair bit packer: bit accumulator and output word register.
//
// channel    modport  payload
// pair_in    sink     pixel_value[7:0], run_length[7:0]
// word_out   source   packed_word[31:0], last_of_item
//
// One pair is taken per cycle while pair_in.ready is high; a completed word passes from
// the accumulator into the output register once that register is free.
// The accumulator holds the partial word plus one pair and moves one word per cycle into
// the output register while that register is empty or read; a pair adds less than a word,
// so it completes at most one word and the accumulator never holds two complete words.
// Reset clears the accumulator, the fill count and the output valid flag.
// A stalled output blocks input only once a complete word waits in the accumulator.
module run_length_pair_bit_packer (
	input logic clk,
	input logic arst_n,
	rlp_in_if.sink pair_in,
	rlp_out_if.source word_out
);

	localparam rlp_pkg::acc_t VAL_MASK =
		{rlp_pkg::ACC_BITS{1'b1}} >> (rlp_pkg::ACC_BITS - rlp_pkg::VALUE_BITS);
	localparam rlp_pkg::acc_t RUN_MASK =
		{rlp_pkg::ACC_BITS{1'b1}} >> (rlp_pkg::ACC_BITS - rlp_pkg::RUN_BITS);
	localparam rlp_pkg::cnt_t WORD_CNT = rlp_pkg::CNT_W'(rlp_pkg::WORD_BITS);
	localparam logic [rlp_pkg::CNT_W:0] TWO_WORD_CNT =
		(rlp_pkg::CNT_W + 1)'(2 * rlp_pkg::WORD_BITS);
	localparam rlp_pkg::cnt_t PAIR_CNT = rlp_pkg::CNT_W'(rlp_pkg::PAIR_BITS);
	localparam rlp_pkg::cnt_t MAX_CNT =
		rlp_pkg::CNT_W'(rlp_pkg::WORD_BITS - 1 + rlp_pkg::PAIR_BITS);

	rlp_pkg::acc_t acc_q;
	rlp_pkg::cnt_t cnt_q;
	logic out_valid_q;
	rlp_pkg::packed_word_t out_word_q;
	logic out_last_q;

	logic emit;
	logic accept;
	rlp_pkg::acc_t pair_bits;
	rlp_pkg::acc_t acc_base;
	rlp_pkg::cnt_t cnt_base;
	rlp_pkg::cnt_t cnt_after_emit;

	always_comb begin
		emit = (cnt_q >= WORD_CNT) && (!out_valid_q || word_out.ready);
		pair_in.ready = (cnt_q < WORD_CNT) || (({1'b0, cnt_q} < TWO_WORD_CNT) && emit);
		accept = pair_in.valid && pair_in.ready;
		cnt_after_emit = cnt_q - WORD_CNT;
		pair_bits = (rlp_pkg::ACC_BITS'(pair_in.pixel_value) & VAL_MASK)
			| ((rlp_pkg::ACC_BITS'(pair_in.run_length) & RUN_MASK) << rlp_pkg::VALUE_BITS);
		if (emit) begin
			acc_base = acc_q >> rlp_pkg::WORD_BITS;
			cnt_base = cnt_after_emit;
		end else begin
			acc_base = acc_q;
			cnt_base = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				acc_q <= acc_base | (pair_bits << cnt_base);
				cnt_q <= cnt_base + PAIR_CNT;
			end else begin
				acc_q <= acc_base;
				cnt_q <= cnt_base;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (word_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= rlp_pkg::OUT_WORD_W'(acc_q[rlp_pkg::WORD_BITS-1:0]);
			out_last_q <= cnt_after_emit < WORD_CNT;
		end
	end

	assign word_out.valid = out_valid_q;
	assign word_out.packed_word = out_word_q;
	assign word_out.last_of_item = out_last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("Fill count exceeds accumulator size.");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> cnt_q) == '0)
		else $error("Accumulator holds bits above the fill count.");

	a_full_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cnt_q >= WORD_CNT)) |-> emit)
		else $error("Pair taken while a complete word stays in the accumulator.");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> word_out.valid)
		else $error("Emitted word did not reach the output register.");
`endif

endmodule

FILE: bench/rlp_pair_checker.sv
// Checker that predicts the packed words from accepted pairs and compares them with the output.
module rlp_pair_checker (
	input logic clk,
	input logic arst_n,
	rlp_in_if pair_mon,
	rlp_out_if word_mon,
	output int unsigned error_count,
	output int unsigned words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rlp_pkg::packed_word_t word;
		logic last;
	} packed_result_t;

	packed_result_t expected_words[$];
	logic [rlp_pkg::WORD_BITS-1:0] fill_word;
	int unsigned fill_bits;
	int unsigned fail_total;

	assign error_count = fail_total;

	function automatic void append_field(input logic [31:0] data, input int unsigned count,
			ref packed_result_t made[$]);
		packed_result_t entry;
		for (int unsigned b = 0; b < count; b++) begin
			fill_word[fill_bits] = data[b];
			fill_bits++;
			if (fill_bits >= rlp_pkg::WORD_BITS) begin
				entry.word = rlp_pkg::packed_word_t'(fill_word);
				entry.last = 1'b0;
				made.push_back(entry);
				fill_word = '0;
				fill_bits = 0;
			end
		end
	endfunction

	function automatic void pack_pair(input rlp_pkg::pixel_value_t value,
			input rlp_pkg::run_length_t run);
		packed_result_t made[$];
		append_field(32'(value), rlp_pkg::VALUE_BITS, made);
		append_field(32'(run), rlp_pkg::RUN_BITS, made);
		if (made.size() != 0) begin
			made[made.size() - 1].last = 1'b1;
		end
		foreach (made[i]) begin
			expected_words.push_back(made[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		packed_result_t want;
		if (!arst_n) begin
			expected_words.delete();
			fill_word = '0;
			fill_bits = 0;
			fail_total = 0;
			words_pending <= 0;
		end else begin
			if (word_mon.valid && word_mon.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h last %b", $time,
						word_mon.packed_word, word_mon.last_of_item);
					fail_total++;
				end else begin
					want = expected_words.pop_front();
					if (word_mon.packed_word !== want.word) begin
						$display("%0t: packed_word mismatch: expected %h, actual %h", $time,
							want.word, word_mon.packed_word);
						fail_total++;
					end
					if (word_mon.last_of_item !== want.last) begin
						$display("%0t: last_of_item mismatch: expected %b, actual %b", $time,
							want.last, word_mon.last_of_item);
						fail_total++;
					end
				end
			end
			if (pair_mon.valid && pair_mon.ready) begin
				pack_pair(pair_mon.pixel_value, pair_mon.run_length);
			end
			words_pending <= expected_words.size();
		end
	end

endmodule

FILE: bench/tb_run_length_pair_bit_packer.sv
// Top of the testbench that drives run-length pairs into the packer and reports the verdict.
module tb_run_length_pair_bit_packer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_PAIRS = 105;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	int unsigned ready_hold = 0;
	int unsigned error_count;
	int unsigned words_pending;

	rlp_in_if pair_in ();
	rlp_out_if word_out ();

	run_length_pair_bit_packer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_in(pair_in),
		.word_out(word_out)
	);

	rlp_pair_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.pair_mon(pair_in),
		.word_mon(word_out),
		.error_count(error_count),
		.words_pending(words_pending)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 20);
	endfunction

	function automatic logic [7:0] pick_field();
		if ($urandom_range(0, 3) == 0) begin
			return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_pair(input rlp_pkg::pixel_value_t value,
			input rlp_pkg::run_length_t run, input int unsigned gap);
		if (gap != 0) begin
			pair_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_in.valid <= 1'b1;
		pair_in.pixel_value <= value;
		pair_in.run_length <= run;
		do @(posedge clk); while (!pair_in.ready);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (ready_hold != 0) begin
				ready_hold <= ready_hold - 1;
			end else if ($urandom_range(0, 3) != 0) begin
				word_out.ready <= 1'b1;
				ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 6);
			end else begin
				word_out.ready <= 1'b0;
				ready_hold <= pick_gap();
			end
		end else begin
			word_out.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		rlp_pkg::pixel_value_t directed_values[$];
		rlp_pkg::run_length_t directed_runs[$];
		arst_n <= 1'b0;
		pair_in.valid <= 1'b0;
		pair_in.pixel_value <= '0;
		pair_in.run_length <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		directed_values = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h01, 8'h80, 8'haa, 8'h55,
			8'h0f, 8'hf0, 8'h12, 8'hed, 8'h7f, 8'hfe};
		directed_runs = '{8'h00, 8'hff, 8'hff, 8'h00, 8'h80, 8'h01, 8'h55, 8'haa,
			8'hf0, 8'h0f, 8'h34, 8'hcb, 8'hfe, 8'h7f};
		foreach (directed_values[i]) begin
			send_pair(directed_values[i], directed_runs[i], 0);
		end
		send_pair(8'h3c, 8'hc3, 0);

		for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
			send_pair(pick_field(), pick_field(), pick_gap());
		end
		pair_in.valid <= 1'b0;

		@(posedge clk);
		while (words_pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
